>>> src/crd_pkg.sv
// Shared constants and register index codes of the camera ray direction block.
package crd_pkg;

  // tan(15 degrees) as unsigned Q0.18
  localparam int unsigned TAN15_Q18 = 70241;
  localparam int unsigned TAN_FRAC  = 18;
  localparam int unsigned TAN_BITS  = 17;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } crd_reg_t;

endpackage

>>> src/camera_ray_direction_top.sv
// Top level of the pinhole camera primary ray direction pipeline.
// One pixel word is taken every cycle while the output is not stalled and gives
// one unit direction word, x and y in signed Q1.FRAC_BITS and z in signed
// Q0.FRAC_BITS. The square root pipeline gives one root bit per stage and the
// divider pipeline one quotient bit per stage. A stall on the output holds
// the whole pipeline and is passed straight back to in_stall; nothing is
// dropped or repeated.
module camera_ray_direction_top import crd_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [COORD_BITS:0]         cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_BITS-1:0]       in_pixel_x,
  input  logic [COORD_BITS-1:0]       in_pixel_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [FRAC_BITS+1:0] out_dir_x,
  output logic signed [FRAC_BITS+1:0] out_dir_y,
  output logic signed [FRAC_BITS:0]   out_dir_z,
  output logic                        out_out_of_range
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int SHR   = (C > 12) ? (C - 12) : 0;
  localparam int PXW   = C + 1 + TAN_BITS;
  localparam int MXW   = PXW - SHR;
  localparam int MZW   = C + 1 + TAN_FRAC - SHR;
  localparam int NW    = 2 * MZW + 1;
  localparam int SW    = (NW + 1) / 2;
  localparam int QW    = F + 1;
  localparam int DW    = MZW + F + 1;
  localparam int STW   = 2 * MXW + MZW + 3;
  localparam int DTW   = 5;
  localparam logic [TAN_BITS-1:0] TAN = TAN_BITS'(TAN15_Q18);
  localparam logic [QW-1:0] ONE = QW'(1) << F;

  logic        en;
  logic [C:0]  width_r;
  logic [C:0]  height_r;

  // global advance: hold everything while the output word is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= (C+1)'(640);
      height_r <= (C+1)'(480);
    end else if (cfg_we) begin
      unique case (crd_reg_t'(cfg_addr))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: signed offsets as sign and magnitude, range flag
  logic [C:0] ax_c, by_c, tx_c, ty_c;
  logic       nx_c, ny_c;
  logic       v1_r, nx1_r, ny1_r, oor1_r;
  logic [C:0] ax1_r, by1_r, h1_r;

  assign tx_c = {in_pixel_x, 1'b1};
  assign ty_c = {in_pixel_y, 1'b1};
  assign nx_c = (tx_c < width_r);
  assign ax_c = nx_c ? (width_r - tx_c) : (tx_c - width_r);
  assign ny_c = (height_r < ty_c);
  assign by_c = ny_c ? (ty_c - height_r) : (height_r - ty_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r  <= ax_c;
      by1_r  <= by_c;
      nx1_r  <= nx_c;
      ny1_r  <= ny_c;
      h1_r   <= height_r;
      oor1_r <= ({1'b0, in_pixel_x} >= width_r) || ({1'b0, in_pixel_y} >= height_r);
    end
  end

  // stage 2: scale the offsets by tan15 and bring the height to the same scale
  logic [PXW-1:0]       px_c, py_c;
  logic [C+TAN_FRAC:0]  pz_c;
  logic                 v2_r, nx2_r, ny2_r, oor2_r;
  logic [MXW-1:0]       mx2_r, my2_r;
  logic [MZW-1:0]       mz2_r;

  assign px_c = {{TAN_BITS{1'b0}}, ax1_r} * {{(C+1){1'b0}}, TAN};
  assign py_c = {{TAN_BITS{1'b0}}, by1_r} * {{(C+1){1'b0}}, TAN};
  assign pz_c = {h1_r, {TAN_FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx2_r  <= MXW'(px_c >> SHR);
      my2_r  <= MXW'(py_c >> SHR);
      mz2_r  <= MZW'(pz_c >> SHR);
      nx2_r  <= nx1_r;
      ny2_r  <= ny1_r;
      oor2_r <= oor1_r;
    end
  end

  // stage 3: squares
  logic [MZW-1:0]   ex_c, ey_c;
  logic             v3_r;
  logic [2*MZW-1:0] sx3_r, sy3_r, sz3_r;
  logic [STW-1:0]   tag3_r;

  assign ex_c = MZW'(mx2_r);
  assign ey_c = MZW'(my2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx3_r  <= {{MZW{1'b0}}, ex_c} * {{MZW{1'b0}}, ex_c};
      sy3_r  <= {{MZW{1'b0}}, ey_c} * {{MZW{1'b0}}, ey_c};
      sz3_r  <= {{MZW{1'b0}}, mz2_r} * {{MZW{1'b0}}, mz2_r};
      tag3_r <= {mx2_r, my2_r, mz2_r, nx2_r, ny2_r, oor2_r};
    end
  end

  // stage 4: sum of squares
  logic           v4_r;
  logic [NW-1:0]  n4_r;
  logic [STW-1:0] tag4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n4_r   <= {1'b0, sx3_r} + {1'b0, sy3_r} + {1'b0, sz3_r};
      tag4_r <= tag3_r;
    end
  end

  // square root
  logic           sq_valid;
  logic [SW-1:0]  sq_root;
  logic [STW-1:0] sq_tag;

  crd_sqrt #(
    .NW    (NW),
    .TAG_W (STW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_n      (n4_r),
    .in_tag    (tag4_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // stage 5: form rounded dividends
  logic [MXW-1:0] mx_s, my_s;
  logic [MZW-1:0] mz_s;
  logic           nx_s, ny_s, oor_s;
  logic [DW-1:0]  d_c [3];
  logic [MZW-1:0] mag_c [3];
  logic           v5_r;
  logic [SW-1:0]  rem5_r [3];
  logic [QW-1:0]  low5_r [3];
  logic [SW-1:0]  s5_r;
  logic [DTW-1:0] tag5_r;

  assign {mx_s, my_s, mz_s, nx_s, ny_s, oor_s} = sq_tag;
  assign mag_c[0] = MZW'(mx_s);
  assign mag_c[1] = MZW'(my_s);
  assign mag_c[2] = mz_s;

  for (genvar l = 0; l < 3; l++) begin : g_div_in
    assign d_c[l] = {1'b0, mag_c[l], {F{1'b0}}} + DW'(sq_root >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        rem5_r[l] <= SW'(d_c[l][DW-1:QW]);
        low5_r[l] <= d_c[l][QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r   <= sq_root;
      tag5_r <= {nx_s && (mx_s != '0), ny_s && (my_s != '0), (mz_s != '0), oor_s,
                 (sq_root == '0)};
    end
  end

  // divide each magnitude by the norm
  logic           dv_valid;
  logic [QW-1:0]  dv_q [3];
  logic [DTW-1:0] dv_tag;

  crd_div #(
    .SW    (SW),
    .QW    (QW),
    .TAG_W (DTW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_rem    (rem5_r),
    .in_low    (low5_r),
    .in_s      (s5_r),
    .in_tag    (tag5_r),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_tag   (dv_tag)
  );

  // output stage: saturate, apply signs, catch a zero norm
  logic [QW-1:0]  qx_c, qy_c, qz_c;
  logic           fnx, fny, fnz, foor, fsz;
  logic [F+1:0]   dx_c, dy_c;
  logic [F:0]     dz_c;
  logic           out_valid_r;
  logic [F+1:0]   dir_x_r, dir_y_r;
  logic [F:0]     dir_z_r;
  logic           oor_r;

  assign {fnx, fny, fnz, foor, fsz} = dv_tag;
  assign qx_c = (dv_q[0] > ONE) ? ONE : dv_q[0];
  assign qy_c = (dv_q[1] > ONE) ? ONE : dv_q[1];
  assign qz_c = (dv_q[2] > ONE) ? ONE : dv_q[2];

  always_comb begin
    dx_c = fnx ? ((F+2)'(0) - {1'b0, qx_c}) : {1'b0, qx_c};
    dy_c = fny ? ((F+2)'(0) - {1'b0, qy_c}) : {1'b0, qy_c};
    dz_c = fnz ? ((F+1)'(0) - qz_c) : qz_c;
    if (fsz) begin
      dx_c = '0;
      dy_c = '0;
      dz_c = (F+1)'(0) - ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_x_r <= dx_c;
      dir_y_r <= dy_c;
      dir_z_r <= dz_c;
      oor_r   <= foor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dir_x        = dir_x_r;
  assign out_dir_y        = dir_y_r;
  assign out_dir_z        = dir_z_r;
  assign out_out_of_range = oor_r;

endmodule

>>> src/crd_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module crd_sqrt import crd_pkg::*; #(
  parameter int NW    = 63,
  parameter int TAG_W = 8,
  localparam int RW   = (NW + 1) / 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NW-1:0]    in_n,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [RW-1:0]    out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int PW = 2 * RW;

  logic [RW-1:0]    v_r;
  logic [RW-1:0]    q_r [RW];
  logic [TAG_W-1:0] t_r [RW];
  logic [RW+1:0]    r_r [RW-1];
  logic [PW-1:0]    n_r [RW-1];

  genvar k;
  for (k = 0; k < RW; k++) begin : g_stage
    logic [PW-1:0]    n_p;
    logic [RW-1:0]    q_p;
    logic [RW+1:0]    r_p;
    logic [TAG_W-1:0] t_p;
    logic             v_p;
    logic [RW+3:0]    cur;
    logic [RW+3:0]    trial;

    // pick up the previous stage, or the input at the head
    if (k == 0) begin : g_head
      assign n_p = PW'(in_n);
      assign q_p = '0;
      assign r_p = '0;
      assign t_p = in_tag;
      assign v_p = in_valid;
    end else begin : g_body
      assign n_p = n_r[k-1];
      assign q_p = q_r[k-1];
      assign r_p = r_r[k-1];
      assign t_p = t_r[k-1];
      assign v_p = v_r[k-1];
    end

    // bring down the next bit pair and try the odd candidate
    assign cur   = {r_p, n_p[2*(RW-1-k) +: 2]};
    assign trial = {2'b00, q_p, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[k] <= t_p;
        q_r[k] <= {q_p[RW-2:0], (cur >= trial)};
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[k] <= n_p;
          if (cur >= trial) begin
            r_r[k] <= (RW+2)'(cur - trial);
          end else begin
            r_r[k] <= cur[RW+1:0];
          end
        end
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = q_r[RW-1];
  assign out_tag   = t_r[RW-1];

endmodule

>>> src/crd_div.sv
// Three-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
module crd_div import crd_pkg::*; #(
  parameter int SW    = 32,
  parameter int QW    = 15,
  parameter int TAG_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SW-1:0]    in_rem  [3],
  input  logic [QW-1:0]    in_low  [3],
  input  logic [SW-1:0]    in_s,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    out_q   [3],
  output logic [TAG_W-1:0] out_tag
);

  logic [QW-1:0]    v_r;
  logic [TAG_W-1:0] t_r   [QW];
  logic [QW-1:0]    q_r   [QW][3];
  logic [SW-1:0]    rem_r [QW-1][3];
  logic [QW-1:0]    low_r [QW-1][3];
  logic [SW-1:0]    s_r   [QW-1];

  genvar k, l;
  for (k = 0; k < QW; k++) begin : g_stage
    logic [SW-1:0]    s_p;
    logic [TAG_W-1:0] t_p;
    logic             v_p;

    if (k == 0) begin : g_head
      assign s_p = in_s;
      assign t_p = in_tag;
      assign v_p = in_valid;
    end else begin : g_body
      assign s_p = s_r[k-1];
      assign t_p = t_r[k-1];
      assign v_p = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[k] <= t_p;
      end
    end

    if (k < QW - 1) begin : g_scarry
      always_ff @(posedge clk) begin
        if (en) begin
          s_r[k] <= s_p;
        end
      end
    end

    for (l = 0; l < 3; l++) begin : g_lane
      logic [SW-1:0] rem_p;
      logic [QW-1:0] low_p;
      logic [QW-1:0] q_p;
      logic [SW:0]   cur;
      logic          take;

      if (k == 0) begin : g_head
        assign rem_p = in_rem[l];
        assign low_p = in_low[l];
        assign q_p   = '0;
      end else begin : g_body
        assign rem_p = rem_r[k-1][l];
        assign low_p = low_r[k-1][l];
        assign q_p   = q_r[k-1][l];
      end

      // shift in the next dividend bit and subtract where it fits
      assign cur  = {rem_p, low_p[QW-1-k]};
      assign take = (cur >= {1'b0, s_p});

      always_ff @(posedge clk) begin
        if (en) begin
          q_r[k][l] <= {q_p[QW-2:0], take};
        end
      end

      if (k < QW - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            low_r[k][l] <= low_p;
            if (take) begin
              rem_r[k][l] <= SW'(cur - {1'b0, s_p});
            end else begin
              rem_r[k][l] <= cur[SW-1:0];
            end
          end
        end
      end

      assign out_q[l] = q_r[QW-1][l];
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_tag   = t_r[QW-1];

endmodule

>>> verif/tb_camera_ray_direction_top.sv
// Testbench of the camera ray direction block: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_camera_ray_direction_top import crd_pkg::*;;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 14;
  localparam int DRAIN_CYCLES = 70;
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic signed [FRAC_BITS+1:0] dir_x;
    logic signed [FRAC_BITS+1:0] dir_y;
    logic signed [FRAC_BITS:0]   dir_z;
    logic                        out_of_range;
  } ray_dir_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [COORD_BITS:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COORD_BITS-1:0] in_pixel_x = '0;
  logic [COORD_BITS-1:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [FRAC_BITS+1:0] out_dir_x;
  logic signed [FRAC_BITS+1:0] out_dir_y;
  logic signed [FRAC_BITS:0]   out_dir_z;
  logic out_out_of_range;

  // Predictor copy of the two registers
  logic [COORD_BITS:0] img_w = 13'd640;
  logic [COORD_BITS:0] img_h = 13'd480;

  ray_dir_t pending_dirs[$];
  int unsigned n_errors = 0;
  int unsigned n_pixels = 0;
  int unsigned n_rays = 0;
  int unsigned n_outside = 0;
  int unsigned n_settings = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  camera_ray_direction_top #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
    .out_out_of_range(out_out_of_range)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rounded, saturated component in two's complement
  function automatic longint unsigned unit_part(longint unsigned mag, bit neg,
                                                longint unsigned s);
    longint unsigned q;
    q = ((mag << FRAC_BITS) + (s >> 1)) / s;
    if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
    if (neg) q = 64'd0 - q;
    return q;
  endfunction

  function automatic ray_dir_t predict_ray(logic [COORD_BITS-1:0] px,
                                           logic [COORD_BITS-1:0] py);
    ray_dir_t r;
    longint unsigned w, h, ax, by, mx, my, mz, s;
    bit nx, ny;
    w = 64'(img_w);
    h = 64'(img_h);
    ax = 2 * longint'(px) + 1;
    if (ax >= w) begin nx = 0; ax = ax - w; end else begin nx = 1; ax = w - ax; end
    by = 2 * longint'(py) + 1;
    if (h >= by) begin ny = 0; by = h - by; end else begin ny = 1; by = by - h; end
    mx = ax * TAN15_Q18;
    my = by * TAN15_Q18;
    mz = h << TAN_FRAC;
    s = root_floor(mx * mx + my * my + mz * mz);
    if (s == 0) begin
      r.dir_x = '0;
      r.dir_y = '0;
      r.dir_z = (FRAC_BITS+1)'(-(16'sd1 <<< FRAC_BITS));
    end else begin
      r.dir_x = (FRAC_BITS+2)'(unit_part(mx, nx && mx != 0, s));
      r.dir_y = (FRAC_BITS+2)'(unit_part(my, ny && my != 0, s));
      r.dir_z = (FRAC_BITS+1)'(unit_part(mz, mz != 0, s));
    end
    r.out_of_range = (px >= w) || (py >= h);
    return r;
  endfunction

  // Send one pixel word; valid stays high after acceptance until the next gap
  task automatic send_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (in_stall);
    pending_dirs.push_back(predict_ray(px, py));
    n_pixels++;
    if (px >= img_w || py >= img_h) n_outside++;
  endtask

  // Drop valid and wait until the pipeline has drained
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [COORD_BITS:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w = val;
    else if (idx == REG_IMAGE_HEIGHT) img_h = val;
  endtask

  task automatic set_image(logic [COORD_BITS:0] w, logic [COORD_BITS:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    n_settings++;
  endtask

  // Result side: check each word, then draw the next stall
  always @(posedge clk) begin
    int n;
    ray_dir_t want;
    n = stall_left;
    if (out_valid && !out_stall) begin
      n_rays++;
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected ray word x=%0d y=%0d z=%0d oor=%0d", $time,
                 out_dir_x, out_dir_y, out_dir_z, out_out_of_range);
        n_errors++;
      end else begin
        want = pending_dirs.pop_front();
        if (out_dir_x !== want.dir_x) begin
          $display("%0t: dir_x expected %0d actual %0d", $time, want.dir_x, out_dir_x);
          n_errors++;
        end
        if (out_dir_y !== want.dir_y) begin
          $display("%0t: dir_y expected %0d actual %0d", $time, want.dir_y, out_dir_y);
          n_errors++;
        end
        if (out_dir_z !== want.dir_z) begin
          $display("%0t: dir_z expected %0d actual %0d", $time, want.dir_z, out_dir_z);
          n_errors++;
        end
        if (out_out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0d actual %0d", $time,
                   want.out_of_range, out_out_of_range);
          n_errors++;
        end
      end
      n = quiet ? 0 : $urandom_range(0, 14);
    end
    if (n > 0) begin
      out_stall <= 1'b1;
      stall_left <= n - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  // Corners, centre and outside pixels of the reset image size
  task automatic test_reset_size;
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(320, 240);
    send_pixel(639, 0);
    send_pixel(640, 100);
    send_pixel(100, 480);
    send_pixel(4095, 4095);
  endtask

  // Extreme sizes, empty image and ignored register indexes
  task automatic test_extremes;
    set_image(1, 1);
    send_pixel(0, 0);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    set_image(4096, 4096);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2048, 2047);
    set_image(8191, 8191);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    // zero sizes: everything is outside, height zero flattens z
    set_image(0, 0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    set_image(0, 7);
    send_pixel(3, 3);
    // writes to spare indexes must change nothing
    set_image(200, 100);
    write_reg(REG_SPARE_2, 13'h1555);
    write_reg(REG_SPARE_3, 13'h0aaa);
    send_pixel(199, 99);
    send_pixel(0, 50);
  endtask

  // Random pixels over several image sizes
  task automatic test_random;
    logic [COORD_BITS:0] w, h;
    logic [COORD_BITS-1:0] px, py;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin w = 640; h = 480; end
        1: begin w = 4096; h = 1; end
        2: begin w = 1; h = 4096; end
        default: begin
          w = (COORD_BITS+1)'($urandom_range(1, 4096));
          h = (COORD_BITS+1)'($urandom_range(1, 4096));
        end
      endcase
      set_image(w, h);
      for (int i = 0; i < 320; i++) begin
        if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0) begin
          px = COORD_BITS'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
          py = COORD_BITS'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
        end else begin
          px = COORD_BITS'($urandom);
          py = COORD_BITS'($urandom);
        end
        send_pixel(px, py);
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_extremes();
    test_random();
    drain();
    $display("covered %0d pixels (%0d outside the image) over %0d image sizes, %0d rays",
             n_pixels, n_outside, n_settings, n_rays);
    if (n_errors == 0 && pending_dirs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
